[src/fqd_pkg.sv]
// Package: operation codes, field widths and cell control for the handle queue.
package fqd_pkg;

	localparam int MODE_W = 2;
	localparam int IN_HANDLE_W = 32;
	localparam int OUT_HANDLE_W = 32;
	localparam int OUT_COUNT_W = 5;
	localparam int IN_TDATA_W = 32;
	localparam int OUT_TDATA_W = 40;

	localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DEL = 2'd2;

	// broadcast to every cell
	typedef struct packed {
		logic go;   // word accepted this cycle
		logic deq;  // successful dequeue: whole row shifts toward head
		logic del;  // delete with nonnull handle: compare and shift above match
	} fqd_ctrl_t;

endpackage

[src/fqd_cell.sv]
// One queue slot: holds a handle, compares it for delete, shifts toward the head.
module fqd_cell #(
	parameter int HW = 32
) (
	input  logic            clk,
	input  fqd_pkg::fqd_ctrl_t ctrl,
	input  logic [HW-1:0]   handle,
	input  logic            valid,
	input  logic            load,
	input  logic [HW-1:0]   next_data,
	input  logic            found_in,
	output logic            found_out,
	output logic [HW-1:0]   data
);

	logic [HW-1:0] data_q;
	logic          match;
	logic          shift;

	assign match     = ctrl.del && valid && (data_q == handle);
	assign found_out = found_in || match;
	assign shift     = ctrl.deq || found_out;
	assign data      = data_q;

	always_ff @(posedge clk) begin
		if (ctrl.go) begin
			if (shift) begin
				data_q <= next_data;
			end else if (load) begin
				data_q <= handle;
			end
		end
	end

endmodule

[src/fifo_queue_with_delete_top.sv]
// Top level: bounded handle queue with enqueue, dequeue and delete by value.
//
//  channel | dir | tdata (low bit up)                   | tuser
//  s_      | in  | item_handle[31:0]                    | mode[1:0]
//  m_      | out | status, out_handle[31:0], count[4:0] | -
//
// Every operation acts on the row of DEPTH cells at once: each cell compares its
// entry and shifts in its neighbor, so one word is taken per cycle unless m_tready stalls.
// Delete settles through the match chain that ripples from head to tail.
// Reset clears the count and the output valid; no clearing pass over the cells.
// The input stalls only while a result waits and m_tready is low.
module fifo_queue_with_delete_top #(
	parameter int DEPTH = 16,
	parameter int HANDLE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // item_handle[31:0]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // status[0], out_handle[32:1], count[37:33], zero
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]           count_q;
	logic [CW-1:0]           count_next;
	logic                    out_valid_q;
	logic [39:0]             out_data_q;
	logic [HANDLE_WIDTH-1:0] handle;
	logic [1:0]              mode;
	logic                    accept;
	logic                    enq_ok;
	logic                    deq_ok;
	logic                    del_ok;
	logic                    status;
	logic [31:0]             out_handle;
	fqd_pkg::fqd_ctrl_t      ctrl;

	logic [HANDLE_WIDTH-1:0] cell_data [DEPTH];
	logic [DEPTH:0]          found;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign mode     = s_tuser;
	assign handle   = HANDLE_WIDTH'(s_tdata);

	assign enq_ok = (mode == fqd_pkg::MODE_ENQ) && (handle != '0)
		&& (count_q < CW'(DEPTH));
	assign deq_ok = (mode == fqd_pkg::MODE_DEQ) && (count_q != '0);
	assign del_ok = found[DEPTH];

	assign ctrl.go  = accept;
	assign ctrl.deq = deq_ok;
	assign ctrl.del = (mode == fqd_pkg::MODE_DEL) && (handle != '0);

	assign found[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [HANDLE_WIDTH-1:0] nxt;
		if (i == DEPTH - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end
		fqd_cell #(
			.HW(HANDLE_WIDTH)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.handle   (handle),
			.valid    (CW'(i) < count_q),
			.load     (enq_ok && (count_q == CW'(i))),
			.next_data(nxt),
			.found_in (found[i]),
			.found_out(found[i+1]),
			.data     (cell_data[i])
		);
	end

	always_comb begin
		count_next = count_q;
		status     = 1'b1;
		if (enq_ok) begin
			count_next = count_q + CW'(1);
			status     = 1'b0;
		end else if (deq_ok || del_ok) begin
			count_next = count_q - CW'(1);
			status     = 1'b0;
		end
	end

	assign out_handle = deq_ok ? 32'(cell_data[0]) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {2'b00, fqd_pkg::OUT_COUNT_W'(count_next), out_handle, status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count above depth");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && enq_ok |=> count_q == $past(count_q) + CW'(1))
		else $error("enqueue did not raise count");

	a_deq_head: assert property (@(posedge clk) disable iff (!arst_n)
		accept && deq_ok |=> m_tdata[32:1] == 32'($past(cell_data[0])))
		else $error("dequeue returned wrong head");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[32:1] == 32'd0)
		else $error("failed result carries a handle");
`endif

endmodule
